[design/stq_pkg.sv]
// shared types, constants and controller/datapath link structs for the timer queue
package stq_pkg;

	localparam int ID_W           = 4;
	localparam int ID_COUNT       = 16;
	localparam int DELAY_W        = 31;
	localparam int TIME_W         = 32;
	localparam int NUM_TIMERS_DEF = 16;

	// item modes
	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_ADD  = 2'd1,
		MODE_DEL  = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	// status codes
	localparam logic STATUS_OK          = 1'b0;
	localparam logic STATUS_NOT_PENDING = 1'b1;

	// wait reported when no timer is pending
	localparam logic signed [TIME_W-1:0] WAIT_EMPTY = -32'sd1;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic scan_clr;
		logic scan_inc;
		logic remove;
		logic insert;
		logic pop;
		logic load_fire;
		logic load_final;
		logic load_resp;
	} stq_cmd_t;

	// datapath to controller status
	typedef struct packed {
		mode_t mode;
		logic  id_ok;
		logic  armed_hit;
		logic  match;
		logic  ins_here;
		logic  head_due;
		logic  out_free;
	} stq_stat_t;

endpackage

[design/stq_in_if.sv]
// input channel: one item per valid/ready handshake
interface stq_in_if import stq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [ID_W-1:0]    timer_id;
	logic [DELAY_W-1:0] delay_ms;
	logic [TIME_W-1:0]  now_ms;

	modport source (output valid, mode, timer_id, delay_ms, now_ms, input ready);
	modport sink   (input valid, mode, timer_id, delay_ms, now_ms, output ready);
endinterface

[design/stq_out_if.sv]
// result channel: one item per valid/ready handshake
interface stq_out_if import stq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [ID_W-1:0]          expired_id;
	logic                     fired;
	logic signed [TIME_W-1:0] next_wait_ms;
	logic                     status;
	logic                     last;

	modport source (output valid, expired_id, fired, next_wait_ms, status, last, input ready);
	modport sink   (input valid, expired_id, fired, next_wait_ms, status, last, output ready);
endinterface

[design/stq_ctrl.sv]
// controller state machine: sequences scans, queue updates and result loads
module stq_ctrl import stq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  stq_stat_t stat,
	output stq_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_REMOVE,
		ST_INSERT,
		ST_TICK,
		ST_RESP
	} state_t;

	state_t state_q;
	state_t state_nx;

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.scan_clr = 1'b1;
				unique case (stat.mode)
					MODE_TICK: state_nx = ST_TICK;
					MODE_ADD: begin
						if (!stat.id_ok)
							state_nx = ST_RESP;
						else if (stat.armed_hit)
							state_nx = ST_REMOVE;
						else
							state_nx = ST_INSERT;
					end
					MODE_DEL:  state_nx = stat.armed_hit ? ST_REMOVE : ST_RESP;
					MODE_NONE: state_nx = ST_RESP;
					default:   state_nx = ST_RESP;
				endcase
			end
			ST_REMOVE: begin
				if (stat.match) begin
					cmd.remove   = 1'b1;
					cmd.scan_clr = 1'b1;
					state_nx     = (stat.mode == MODE_ADD) ? ST_INSERT : ST_RESP;
				end else begin
					cmd.scan_inc = 1'b1;
				end
			end
			ST_INSERT: begin
				if (stat.ins_here) begin
					cmd.insert = 1'b1;
					state_nx   = ST_RESP;
				end else begin
					cmd.scan_inc = 1'b1;
				end
			end
			ST_TICK: begin
				if (stat.out_free) begin
					if (stat.head_due) begin
						cmd.load_fire = 1'b1;
						cmd.pop       = 1'b1;
					end else begin
						cmd.load_final = 1'b1;
						state_nx       = ST_IDLE;
					end
				end
			end
			ST_RESP: begin
				if (stat.out_free) begin
					cmd.load_resp = 1'b1;
					state_nx      = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// a removal scan only runs for a timer that is pending
	a_remove_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECODE && state_nx == ST_REMOVE) |-> stat.armed_hit)
		else $error("removal scan started for a timer that is not pending");

	// an item taken while idle moves on to decode
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_DECODE))
		else $error("accepted item did not move to decode");

	// a popped head always goes out as a fired result
	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (cmd.load_fire && state_q == ST_TICK))
		else $error("queue head popped outside a tick");

endmodule

[design/stq_dp.sv]
// datapath: sorted queue of ids and deadlines, armed flags, scan pointer, result register
module stq_dp import stq_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  stq_cmd_t                 cmd,
	output stq_stat_t                stat,
	input  logic [1:0]               mode,
	input  logic [ID_W-1:0]          timer_id,
	input  logic [DELAY_W-1:0]       delay_ms,
	input  logic [TIME_W-1:0]        now_ms,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ID_W-1:0]          expired_id,
	output logic                     fired,
	output logic signed [TIME_W-1:0] next_wait_ms,
	output logic                     status,
	output logic                     last
);

	// queue holds at most one entry per usable id
	localparam int QDEPTH = (NUM_TIMERS < ID_COUNT) ? NUM_TIMERS : ID_COUNT;
	localparam int QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	// wrap-aware: a is strictly after b
	function automatic logic later_than(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return (d != '0) && !d[TIME_W-1];
	endfunction

	logic [ID_W-1:0]   q_id_q [QDEPTH];
	logic [TIME_W-1:0] q_dl_q [QDEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  scan_q;
	logic [ID_COUNT-1:0] armed_q;

	mode_t             mode_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] when_q;
	logic [TIME_W-1:0] now_q;
	logic              st_q;
	logic              id_ok_q;

	logic                     out_valid_q;
	logic [ID_W-1:0]          out_id_q;
	logic                     out_fired_q;
	logic signed [TIME_W-1:0] out_wait_q;
	logic                     out_status_q;
	logic                     out_last_q;

	logic              id_ok_in;
	logic [QIDX_W-1:0] sel;
	logic [ID_W-1:0]   scan_id;
	logic [TIME_W-1:0] scan_dl;
	logic [CNT_W-1:0]  rm_pos;
	logic [TIME_W-1:0] head_diff;
	logic [TIME_W-1:0] wait_val;
	logic              out_free;

	// entry under the scan pointer
	assign id_ok_in = 32'(timer_id) < NUM_TIMERS;
	assign sel      = (scan_q < CNT_W'(QDEPTH)) ? scan_q[QIDX_W-1:0] : '0;
	assign scan_id  = q_id_q[sel];
	assign scan_dl  = q_dl_q[sel];
	assign rm_pos   = cmd.pop ? '0 : scan_q;

	// wait until the head deadline, clipped at zero, or WAIT_EMPTY when the queue is empty
	assign head_diff = q_dl_q[0] - now_q;
	assign wait_val  = (count_q == '0) ? WAIT_EMPTY :
		(head_diff[TIME_W-1] ? '0 : head_diff);

	assign out_free = !out_valid_q || out_ready;

	// status to the controller
	always_comb begin
		stat.mode      = mode_q;
		stat.id_ok     = id_ok_q;
		stat.armed_hit = id_ok_q && armed_q[id_q];
		stat.match     = scan_id == id_q;
		stat.ins_here  = (scan_q == count_q) || later_than(scan_dl, when_q);
		stat.head_due  = (count_q != '0) && !later_than(q_dl_q[0], now_q);
		stat.out_free  = out_free;
	end

	// captured item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= mode_t'(mode);
			id_q    <= timer_id;
			id_ok_q <= id_ok_in;
			now_q   <= now_ms;
			when_q  <= now_ms + TIME_W'(delay_ms);
			st_q    <= (mode_t'(mode) == MODE_DEL && !(id_ok_in && armed_q[timer_id])) ?
				STATUS_NOT_PENDING : STATUS_OK;
		end
	end

	// queue entries: close the gap on removal, open one on insertion
	always_ff @(posedge clk) begin
		for (int j = 0; j < QDEPTH; j++) begin
			if (cmd.remove || cmd.pop) begin
				if (CNT_W'(j) >= rm_pos && j < QDEPTH - 1) begin
					q_id_q[j] <= q_id_q[(j + 1) % QDEPTH];
					q_dl_q[j] <= q_dl_q[(j + 1) % QDEPTH];
				end
			end else if (cmd.insert) begin
				if (CNT_W'(j) == scan_q) begin
					q_id_q[j] <= id_q;
					q_dl_q[j] <= when_q;
				end else if (CNT_W'(j) > scan_q && j > 0) begin
					q_id_q[j] <= q_id_q[(j + QDEPTH - 1) % QDEPTH];
					q_dl_q[j] <= q_dl_q[(j + QDEPTH - 1) % QDEPTH];
				end
			end
		end
	end

	// fill count, armed flags and scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			armed_q <= '0;
			scan_q  <= '0;
		end else begin
			if (cmd.remove) begin
				count_q        <= count_q - 1'b1;
				armed_q[id_q]  <= 1'b0;
			end else if (cmd.pop) begin
				count_q           <= count_q - 1'b1;
				armed_q[q_id_q[0]] <= 1'b0;
			end else if (cmd.insert) begin
				count_q       <= count_q + 1'b1;
				armed_q[id_q] <= 1'b1;
			end
			if (cmd.scan_clr)
				scan_q <= '0;
			else if (cmd.scan_inc)
				scan_q <= scan_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_fire || cmd.load_final || cmd.load_resp) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_fire) begin
			out_id_q     <= q_id_q[0];
			out_fired_q  <= 1'b1;
			out_wait_q   <= '0;
			out_status_q <= STATUS_OK;
			out_last_q   <= 1'b0;
		end else if (cmd.load_final) begin
			out_id_q     <= '0;
			out_fired_q  <= 1'b0;
			out_wait_q   <= wait_val;
			out_status_q <= STATUS_OK;
			out_last_q   <= 1'b1;
		end else if (cmd.load_resp) begin
			out_id_q     <= '0;
			out_fired_q  <= 1'b0;
			out_wait_q   <= '0;
			out_status_q <= st_q;
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign expired_id   = out_id_q;
	assign fired        = out_fired_q;
	assign next_wait_ms = out_wait_q;
	assign status       = out_status_q;
	assign last         = out_last_q;

	// fill count stays within the queue
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QDEPTH))
		else $error("queue fill count beyond depth");

	// one armed flag per queued entry
	a_armed_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(armed_q) == 32'(count_q))
		else $error("armed flags disagree with fill count");

	// a result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_fire || cmd.load_final || cmd.load_resp) |-> out_free)
		else $error("result register overwritten");

	// a removed timer is no longer pending
	a_remove_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.remove |=> !armed_q[$past(id_q)])
		else $error("removed timer still armed");

endmodule

[design/sorted_timer_queue.sv]
// top level of the sorted one-shot timer queue
//
// Channels: request (sink) takes items with mode, timer_id, delay_ms and now_ms;
// result (source) gives expired_id, fired, next_wait_ms, status and last.
// Both use valid/ready; an item moves when both are high at a clock edge.
// Add and delete give one result each; a tick gives one fired result per
// expired timer, in deadline order, then a final result with next_wait_ms.
// Timing: one item is worked on at a time. The controller takes the item,
// then decodes it. A delete or rearm scans the queue one entry per cycle to
// find the id, and an add scans one entry per cycle for its slot; then the
// result is loaded. A tick loads one result per cycle while the receiver keeps
// up, and pauses whenever the result register is still full.
// The single result register lets the next item be taken while the last
// result of the previous one still waits. When the receiver stalls, the block
// holds its result and pauses the sequence until it is taken.
// Reset clears all pending timers and the result valid flag; no clearing pass.
module sorted_timer_queue import stq_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	stq_in_if.sink    request,
	stq_out_if.source result
);

	stq_cmd_t  cmd;
	stq_stat_t stat;
	logic      in_ready;

	assign request.ready = in_ready;

	// sequencing
	stq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// queue storage and result register
	stq_dp #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.mode         (request.mode),
		.timer_id     (request.timer_id),
		.delay_ms     (request.delay_ms),
		.now_ms       (request.now_ms),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.expired_id   (result.expired_id),
		.fired        (result.fired),
		.next_wait_ms (result.next_wait_ms),
		.status       (result.status),
		.last         (result.last)
	);

endmodule

[tb/sorted_timer_queue_test.sv]
// self-checking testbench for the sorted one-shot timer queue
`timescale 1ns / 100ps

module sorted_timer_queue_test;
	import stq_pkg::*;

	localparam int TQ_SIZE      = NUM_TIMERS_DEF;
	localparam int RANDOM_ITEMS = 150;
	localparam int MAX_GAP      = 13;
	localparam int LONG_HOLD    = 300;
	localparam int STALL_LIMIT  = 3000;
	localparam int END_CYCLES   = 60;
	localparam int MAX_PRINTED  = 40;

	// one result as the block reports it
	typedef struct packed {
		logic [ID_W-1:0]          expired_id;
		logic                     fired;
		logic signed [TIME_W-1:0] next_wait;
		logic                     status;
		logic                     last;
	} report_t;

	// one directed item, with its result typed in where it is obvious
	typedef struct {
		mode_t              mode;
		logic [ID_W-1:0]    timer_id;
		logic [DELAY_W-1:0] delay_ms;
		logic [TIME_W-1:0]  now_ms;
		bit                 typed;
		report_t            exp;
	} stim_row_t;

	typedef enum {SEQ_FILL, SEQ_HOLD, SEQ_NOISE, SEQ_JUMP, SEQ_OP} seq_kind_t;

	localparam report_t NO_REPORT   = '0;
	localparam report_t ACK_OK      = '{expired_id: '0, fired: 1'b0, next_wait: '0,
		status: STATUS_OK, last: 1'b1};
	localparam report_t ACK_MISSING = '{expired_id: '0, fired: 1'b0, next_wait: '0,
		status: STATUS_NOT_PENDING, last: 1'b1};
	localparam report_t EMPTY_TICK  = '{expired_id: '0, fired: 1'b0, next_wait: WAIT_EMPTY,
		status: STATUS_OK, last: 1'b1};
	localparam report_t FAR_TICK    = '{expired_id: '0, fired: 1'b0,
		next_wait: 32'sh7FFF_FFFF, status: STATUS_OK, last: 1'b1};

	// directed items: extremes, every mode, ties, rearm and wrap of the clock
	stim_row_t directed_rows [0:20] = '{
		'{MODE_TICK, 4'd0,  31'd0,           32'd0,           1'b1, EMPTY_TICK},
		'{MODE_DEL,  4'd5,  31'd0,           32'd0,           1'b1, ACK_MISSING},
		'{MODE_NONE, 4'd15, 31'h7FFF_FFFF,   32'hFFFF_FFFF,   1'b1, ACK_OK},
		'{MODE_ADD,  4'd0,  31'd0,           32'd0,           1'b1, ACK_OK},
		'{MODE_ADD,  4'd15, 31'h7FFF_FFFF,   32'hFFFF_FFFF,   1'b1, ACK_OK},
		'{MODE_ADD,  4'd3,  31'd100,         32'd100,         1'b1, ACK_OK},
		'{MODE_ADD,  4'd4,  31'd100,         32'd100,         1'b1, ACK_OK},
		'{MODE_ADD,  4'd3,  31'd150,         32'd50,          1'b1, ACK_OK},
		'{MODE_TICK, 4'd0,  31'd0,           32'd0,           1'b0, NO_REPORT},
		'{MODE_DEL,  4'd0,  31'd0,           32'd0,           1'b1, ACK_MISSING},
		'{MODE_DEL,  4'd4,  31'd0,           32'd0,           1'b1, ACK_OK},
		'{MODE_TICK, 4'd0,  31'd0,           32'd300,         1'b0, NO_REPORT},
		'{MODE_TICK, 4'd0,  31'd0,           32'h8000_0000,   1'b0, NO_REPORT},
		'{MODE_ADD,  4'd7,  31'h7FFF_FFFF,   32'd0,           1'b1, ACK_OK},
		'{MODE_TICK, 4'd0,  31'd0,           32'd0,           1'b1, FAR_TICK},
		'{MODE_ADD,  4'd9,  31'd0,           32'hFFFF_FFFF,   1'b1, ACK_OK},
		'{MODE_TICK, 4'd0,  31'd0,           32'hFFFF_FFFF,   1'b0, NO_REPORT},
		'{MODE_ADD,  4'd1,  31'd5,           32'd10,          1'b1, ACK_OK},
		'{MODE_ADD,  4'd2,  31'd5,           32'd10,          1'b1, ACK_OK},
		'{MODE_TICK, 4'd0,  31'd0,           32'd14,          1'b0, NO_REPORT},
		'{MODE_TICK, 4'd0,  31'd0,           32'd15,          1'b0, NO_REPORT}
	};

	logic clk;
	logic arst_n;

	stq_in_if  req_ch ();
	stq_out_if res_ch ();

	sorted_timer_queue u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_ch),
		.result (res_ch)
	);

	// expected view of the timer queue
	logic              tq_armed    [TQ_SIZE];
	logic [TIME_W-1:0] tq_deadline [TQ_SIZE];
	logic [ID_W-1:0]   tq_order    [TQ_SIZE];
	int                tq_count;

	report_t step_reports    [$];
	report_t awaited_reports [$];
	report_t want;

	// typed result that travels with the item on the request channel
	bit      row_typed;
	report_t row_expect;

	int          mismatch_count;
	int          items_sent;
	int          stall_cycles;
	bit          no_idle;
	bit          long_hold_req;
	logic [31:0] clk_ms;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// wrap-aware: a lies strictly after b
	function automatic bit is_after(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] diff;
		diff = a - b;
		return diff != '0 && !diff[TIME_W-1];
	endfunction

	function automatic report_t make_report(input logic [ID_W-1:0] id, input logic fired,
		input logic [TIME_W-1:0] wait_ms, input logic status, input logic last);
		report_t r;
		r.expired_id = id;
		r.fired      = fired;
		r.next_wait  = wait_ms;
		r.status     = status;
		r.last       = last;
		return r;
	endfunction

	// take a timer out of the queue and disarm it
	function automatic void drop_timer(input logic [ID_W-1:0] id);
		int pos;
		pos = -1;
		for (int i = 0; i < tq_count; i++)
			if (pos < 0 && tq_order[i] == id)
				pos = i;
		if (pos >= 0) begin
			for (int j = pos; j + 1 < tq_count; j++)
				tq_order[j] = tq_order[j + 1];
			tq_count--;
		end
		tq_armed[id] = 1'b0;
	endfunction

	// insert behind every timer whose deadline is not later
	function automatic void queue_timer(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] when);
		int pos;
		if (tq_count >= TQ_SIZE)
			return;
		pos = tq_count;
		for (int i = tq_count - 1; i >= 0; i--)
			if (is_after(tq_deadline[tq_order[i]], when))
				pos = i;
		for (int i = tq_count; i > pos; i--)
			tq_order[i] = tq_order[i - 1];
		tq_order[pos]   = id;
		tq_count++;
		tq_deadline[id] = when;
		tq_armed[id]    = 1'b1;
	endfunction

	// work out the results of one item and update the expected queue
	function automatic void predict_timer_item(input mode_t mode, input logic [ID_W-1:0] id,
		input logic [DELAY_W-1:0] delay, input logic [TIME_W-1:0] now);
		logic [ID_W-1:0]   head;
		logic [TIME_W-1:0] gap_ms;
		step_reports.delete();
		case (mode)
			MODE_TICK: begin
				while (tq_count > 0 && !is_after(tq_deadline[tq_order[0]], now)) begin
					head = tq_order[0];
					drop_timer(head);
					step_reports.push_back(make_report(head, 1'b1, '0, STATUS_OK, 1'b0));
				end
				if (tq_count == 0) begin
					gap_ms = WAIT_EMPTY;
				end else begin
					gap_ms = tq_deadline[tq_order[0]] - now;
					if (gap_ms[TIME_W-1])
						gap_ms = '0;
				end
				step_reports.push_back(make_report('0, 1'b0, gap_ms, STATUS_OK, 1'b1));
			end
			MODE_ADD: begin
				if (tq_armed[id])
					drop_timer(id);
				queue_timer(id, now + {1'b0, delay});
				step_reports.push_back(ACK_OK);
			end
			MODE_DEL: begin
				if (tq_armed[id]) begin
					drop_timer(id);
					step_reports.push_back(ACK_OK);
				end else begin
					step_reports.push_back(ACK_MISSING);
				end
			end
			default: begin
				step_reports.push_back(ACK_OK);
			end
		endcase
	endfunction

	// predict on every accepted item, check every accepted result
	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready) begin
			predict_timer_item(mode_t'(req_ch.mode), req_ch.timer_id, req_ch.delay_ms,
				req_ch.now_ms);
			if (row_typed)
				awaited_reports.push_back(row_expect);
			else
				foreach (step_reports[k])
					awaited_reports.push_back(step_reports[k]);
		end
		if (res_ch.valid && res_ch.ready) begin
			if (awaited_reports.size() == 0) begin
				note_mismatch($sformatf("result id %0d fired %0b last %0b with nothing awaited",
					res_ch.expired_id, res_ch.fired, res_ch.last));
			end else begin
				want = awaited_reports.pop_front();
				if (res_ch.expired_id !== want.expired_id)
					note_mismatch($sformatf("expired_id %0d, expected %0d",
						res_ch.expired_id, want.expired_id));
				if (res_ch.fired !== want.fired)
					note_mismatch($sformatf("fired %0b, expected %0b", res_ch.fired, want.fired));
				if (res_ch.next_wait_ms !== want.next_wait)
					note_mismatch($sformatf("next_wait_ms %0d, expected %0d",
						res_ch.next_wait_ms, want.next_wait));
				if (res_ch.status !== want.status)
					note_mismatch($sformatf("status %0b, expected %0b", res_ch.status, want.status));
				if (res_ch.last !== want.last)
					note_mismatch($sformatf("last %0b, expected %0b", res_ch.last, want.last));
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("sorted_timer_queue_test: done, errors");
			$finish;
		end
	end

	// result side: random stalls, and one long hold when asked
	initial begin : result_sink
		int hold;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end else if (no_idle) begin
				hold = 0;
			end else begin
				hold = $urandom_range(0, MAX_GAP);
			end
			if (hold != 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// offer one item after a random gap (none while no_idle is set) and wait until it is taken
	task automatic send_item(input mode_t mode, input logic [ID_W-1:0] id,
		input logic [DELAY_W-1:0] delay, input logic [TIME_W-1:0] now,
		input bit typed, input report_t exp);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.mode     <= mode;
		req_ch.timer_id <= id;
		req_ch.delay_ms <= delay;
		req_ch.now_ms   <= now;
		row_typed       <= typed;
		row_expect      <= exp;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	// stop offering until every awaited result has come
	task automatic wait_for_drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (awaited_reports.size() != 0);
	endtask

	// one ordinary operation against the running millisecond clock
	task automatic send_timer_op();
		int pick;
		logic [DELAY_W-1:0] delay;
		pick = $urandom_range(0, 5);
		if (pick <= 2) begin
			delay = ($urandom_range(0, 7) == 0) ? DELAY_W'($urandom) : DELAY_W'($urandom_range(0, 60));
			send_item(MODE_ADD, ID_W'($urandom), delay, clk_ms, 1'b0, NO_REPORT);
		end else if (pick == 3) begin
			send_item(MODE_DEL, ID_W'($urandom), DELAY_W'($urandom), $urandom, 1'b0, NO_REPORT);
		end else begin
			clk_ms = clk_ms + $urandom_range(0, 30);
			send_item(MODE_TICK, ID_W'($urandom), DELAY_W'($urandom), clk_ms, 1'b0, NO_REPORT);
		end
	endtask

	// arm every timer in random order, then fire them all in one tick
	task automatic fill_and_fire();
		logic [ID_W-1:0] ids [TQ_SIZE];
		logic [ID_W-1:0] swap;
		int spread;
		int j;
		for (int i = 0; i < TQ_SIZE; i++)
			ids[i] = ID_W'(i);
		for (int i = TQ_SIZE - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			swap   = ids[i];
			ids[i] = ids[j];
			ids[j] = swap;
		end
		spread = $urandom_range(0, 1) ? 3 : 40;
		for (int i = 0; i < TQ_SIZE; i++)
			send_item(MODE_ADD, ids[i], DELAY_W'($urandom_range(0, spread)), clk_ms, 1'b0, NO_REPORT);
		clk_ms = clk_ms + spread + 1;
		send_item(MODE_TICK, ID_W'($urandom), DELAY_W'($urandom), clk_ms, 1'b0, NO_REPORT);
		wait_for_drain();
	endtask

	// main sequence
	initial begin : stimulus
		int        target;
		int        seq_index;
		bit        saved_idle;
		seq_kind_t kind;
		arst_n          = 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.mode     <= MODE_NONE;
		req_ch.timer_id <= '0;
		req_ch.delay_ms <= '0;
		req_ch.now_ms   <= '0;
		row_typed       <= 1'b0;
		row_expect      <= NO_REPORT;
		mismatch_count  = 0;
		items_sent      = 0;
		no_idle         = 1'b0;
		long_hold_req   = 1'b0;
		tq_count        = 0;
		for (int i = 0; i < TQ_SIZE; i++) begin
			tq_armed[i]    = 1'b0;
			tq_deadline[i] = '0;
			tq_order[i]    = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (directed_rows[i])
			send_item(directed_rows[i].mode, directed_rows[i].timer_id, directed_rows[i].delay_ms,
				directed_rows[i].now_ms, directed_rows[i].typed, directed_rows[i].exp);
		wait_for_drain();

		// random part, mostly ordinary use of a running clock
		clk_ms    = $urandom;
		target    = items_sent + RANDOM_ITEMS;
		seq_index = 0;
		while (items_sent < target) begin
			if (seq_index == 0) begin
				kind = SEQ_FILL;
			end else if (seq_index == 6) begin
				kind = SEQ_HOLD;
			end else begin
				case ($urandom_range(0, 19))
					0:       kind = SEQ_FILL;
					1:       kind = SEQ_HOLD;
					2, 3:    kind = SEQ_NOISE;
					4:       kind = SEQ_JUMP;
					default: kind = SEQ_OP;
				endcase
			end
			case (kind)
				SEQ_FILL: begin
					fill_and_fire();
				end
				SEQ_HOLD: begin
					saved_idle    = no_idle;
					no_idle       = 1'b1;
					long_hold_req = 1'b1;
					repeat (6) send_timer_op();
					no_idle       = saved_idle;
				end
				SEQ_NOISE: begin
					send_item(mode_t'($urandom_range(0, 3)), ID_W'($urandom), DELAY_W'($urandom),
						$urandom, 1'b0, NO_REPORT);
				end
				SEQ_JUMP: begin
					clk_ms  = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 80);
					no_idle = ($urandom_range(0, 2) == 0);
				end
				default: begin
					send_timer_op();
				end
			endcase
			seq_index++;
		end

		wait_for_drain();
		repeat (END_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("sorted_timer_queue_test: done, clean");
		else
			$display("sorted_timer_queue_test: done, errors");
		$finish;
	end

endmodule

[filelist.f]
design/stq_pkg.sv
design/stq_in_if.sv
design/stq_out_if.sv
design/stq_ctrl.sv
design/stq_dp.sv
design/sorted_timer_queue.sv
tb/sorted_timer_queue_test.sv
